// ===== sv/rgb_to_hsv_converter_top_defines.svh =====
// Assertion macros for the RGB to HSV converter checker.
// No dependencies; included by the checker file only.
`ifndef RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH

// Property checked while out of reset.
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define RHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rhc_pkg.sv =====
// Shared widths, constants, types and the divider step for the RGB to HSV converter.
// No dependencies.
package rhc_pkg;

  localparam int COMP_W   = 8;   // bits per colour component
  localparam int HUE_FRAC = 6;   // hue fraction bits (1/64 degree)

  localparam int HUE_W  = HUE_FRAC + 9;
  localparam int DEG60  = 60 << HUE_FRAC;
  localparam int DEG360 = 360 << HUE_FRAC;
  localparam int CMAX   = (1 << COMP_W) - 1;

  // quotient bits: one divider cell per bit
  localparam int HQ_W  = HUE_FRAC + 6;
  localparam int QW    = (COMP_W > HQ_W) ? COMP_W : HQ_W;
  localparam int DIV_W = COMP_W + QW;
  localparam int NCELL = QW;

  localparam int IN_TW   = ((3 * COMP_W + 7) / 8) * 8;
  localparam int OUT_BW  = HUE_W + 2 * COMP_W;
  localparam int OUT_TW  = ((OUT_BW + 7) / 8) * 8;

  // field positions in out_tdata
  localparam int HUE_LSB = 0;
  localparam int SAT_LSB = HUE_W;
  localparam int VAL_LSB = HUE_W + COMP_W;

  localparam logic [HUE_W-1:0] OFS_RED   = '0;
  localparam logic [HUE_W-1:0] OFS_GREEN = HUE_W'(2 * DEG60);
  localparam logic [HUE_W-1:0] OFS_BLUE  = HUE_W'(4 * DEG60);
  localparam logic [HUE_W-1:0] HUE_WRAP  = HUE_W'(DEG360);
  localparam logic [HUE_W-1:0] HUE_LIMIT = HUE_W'(DEG360);

  // partial remainder and shifting dividend/quotient word of one division
  typedef struct packed {
    logic [COMP_W-1:0] rem;
    logic [QW-1:0]     lo;
    logic [COMP_W-1:0] dvs;
  } div_t;

  // per-pixel data carried alongside the divisions
  typedef struct packed {
    logic [COMP_W-1:0] value;
    logic [HUE_W-1:0]  offset;
    logic              neg;
    logic              grey;
  } side_t;

  // one restoring step: bring down the next dividend bit, shift in a quotient bit
  function automatic div_t div_step(div_t d);
    logic [COMP_W:0] t;
    logic [COMP_W:0] diff;
    logic            ge;
    div_t            o;
    t    = {d.rem, d.lo[QW-1]};
    diff = t - {1'b0, d.dvs};
    ge   = (t >= {1'b0, d.dvs});
    o.rem = ge ? diff[COMP_W-1:0] : t[COMP_W-1:0];
    o.lo  = {d.lo[QW-2:0], ge};
    o.dvs = d.dvs;
    return o;
  endfunction

endpackage

// ===== sv/rhc_front.sv =====
// Input stage: max/min, sector choice and the two dividends, registered.
// Depends on rhc_pkg.
module rhc_front import rhc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [COMP_W-1:0] red,
  input  logic [COMP_W-1:0] green,
  input  logic [COMP_W-1:0] blue,
  output logic              valid_r,
  output div_t              sat_r,
  output div_t              hue_r,
  output side_t             side_r
);

  logic [COMP_W-1:0] mx, mn, delta, opa, opb, diff;
  logic [HUE_W-1:0]  ofs;
  logic [DIV_W-1:0]  sat_dvd, hue_dvd;
  div_t              sat_nxt, hue_nxt;
  side_t             side_nxt;

  always_comb begin
    mx = (red > green) ? red : green;
    mx = (mx > blue) ? mx : blue;
    mn = (red < green) ? red : green;
    mn = (mn < blue) ? mn : blue;
    delta = mx - mn;

    // red wins ties, then green
    if (red == mx) begin
      opa = green; opb = blue;  ofs = OFS_RED;
    end else if (green == mx) begin
      opa = blue;  opb = red;   ofs = OFS_GREEN;
    end else begin
      opa = red;   opb = green; ofs = OFS_BLUE;
    end
    diff = (opa >= opb) ? (opa - opb) : (opb - opa);

    sat_dvd = DIV_W'(delta) * DIV_W'(CMAX);
    hue_dvd = DIV_W'(diff) * DIV_W'(DEG60);

    // quotient is known to fit QW bits, so the upper part seeds the remainder
    sat_nxt.rem = sat_dvd[DIV_W-1:QW];
    sat_nxt.lo  = sat_dvd[QW-1:0];
    sat_nxt.dvs = mx;
    hue_nxt.rem = hue_dvd[DIV_W-1:QW];
    hue_nxt.lo  = hue_dvd[QW-1:0];
    hue_nxt.dvs = delta;

    side_nxt.value  = mx;
    side_nxt.offset = ofs;
    side_nxt.neg    = (opa < opb);
    side_nxt.grey   = (delta == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r  <= sat_nxt;
      hue_r  <= hue_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

// ===== sv/rhc_cell.sv =====
// Divider cell: one quotient bit of both the saturation and hue divisions.
// Depends on rhc_pkg.
module rhc_cell import rhc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  valid_i,
  input  div_t  sat_i,
  input  div_t  hue_i,
  input  side_t side_i,
  output logic  valid_r,
  output div_t  sat_r,
  output div_t  hue_r,
  output side_t side_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r  <= div_step(sat_i);
      hue_r  <= div_step(hue_i);
      side_r <= side_i;
    end
  end

endmodule

// ===== sv/rhc_back.sv =====
// Output stage: sector offset and wrap on the hue quotient, result register.
// Depends on rhc_pkg.
module rhc_back import rhc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [QW-1:0]     q_sat,
  input  logic [QW-1:0]     q_hue,
  input  side_t             side_i,
  output logic              valid_r,
  output logic [HUE_W-1:0]  hue_r,
  output logic [COMP_W-1:0] sat_r,
  output logic [COMP_W-1:0] value_r
);

  localparam int SW = ((HUE_W > QW) ? HUE_W : QW) + 2;

  logic [SW-1:0]     q, ofs, sum;
  logic [HUE_W-1:0]  hue_nxt;
  logic [COMP_W-1:0] sat_nxt;

  always_comb begin
    q   = SW'(q_hue);
    ofs = SW'(side_i.offset);
    if (!side_i.neg) begin
      sum = ofs + q;
    end else if (q > ofs) begin
      sum = ofs + SW'(HUE_WRAP) - q;
    end else begin
      sum = ofs - q;
    end
    hue_nxt = side_i.grey ? '0 : sum[HUE_W-1:0];
    sat_nxt = side_i.grey ? '0 : q_sat[COMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      value_r <= side_i.value;
    end
  end

endmodule

// ===== sv/rgb_to_hsv_converter_top.sv =====
// Top level of the RGB to HSV converter: front stage, divider cell row, output stage.
// Depends on rhc_pkg, rhc_front, rhc_cell, rhc_back.
//
// Takes one pixel per clock while the pipeline moves and gives one HSV word per pixel,
// in order (one front stage, a row of 12 divider cells that each settle one quotient
// bit of the saturation and hue divisions, one output register). The row length
// equals the hue quotient width. The whole pipeline moves whenever the output
// register is empty or being read, so in_tready is high exactly then, and a stall at the
// output stops the row without losing a word. Grey and black pixels give hue and
// saturation of zero. Hue is in 1/64 degree, 0 to 23039.
module rgb_to_hsv_converter_top import rhc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata   // hue [14:0], saturation [22:15], value [30:23]
);

  logic              en;
  logic              vld [NCELL+1];
  div_t              sat [NCELL+1];
  div_t              hue [NCELL+1];
  side_t             side[NCELL+1];
  logic [HUE_W-1:0]  hue_o;
  logic [COMP_W-1:0] sat_o, value_o;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  rhc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_tvalid),
    .red     (in_tdata[COMP_W-1:0]),
    .green   (in_tdata[2*COMP_W-1:COMP_W]),
    .blue    (in_tdata[3*COMP_W-1:2*COMP_W]),
    .valid_r (vld[0]),
    .sat_r   (sat[0]),
    .hue_r   (hue[0]),
    .side_r  (side[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rhc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (vld[i]),
      .sat_i   (sat[i]),
      .hue_i   (hue[i]),
      .side_i  (side[i]),
      .valid_r (vld[i+1]),
      .sat_r   (sat[i+1]),
      .hue_r   (hue[i+1]),
      .side_r  (side[i+1])
    );
  end

  rhc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (vld[NCELL]),
    .q_sat   (sat[NCELL].lo),
    .q_hue   (hue[NCELL].lo),
    .side_i  (side[NCELL]),
    .valid_r (out_tvalid),
    .hue_r   (hue_o),
    .sat_r   (sat_o),
    .value_r (value_o)
  );

  assign out_tdata = OUT_TW'({value_o, sat_o, hue_o});

endmodule

// ===== sv/rhc_checker.sv =====
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter_top_defines.svh.
`include "rgb_to_hsv_converter_top_defines.svh"

module rhc_checker import rhc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata
);

  logic [HUE_W-1:0]  hue;
  logic [COMP_W-1:0] sat;

  assign hue = out_tdata[HUE_LSB +: HUE_W];
  assign sat = out_tdata[SAT_LSB +: COMP_W];

  // a stalled word stays until taken
  `RHC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "output word dropped")
  // empty output register never back-pressures the input
  `RHC_ASSERT(a_in_ready, !out_tvalid |-> in_tready, "input stalled with empty output")
  `RHC_ASSERT(a_hue_range, out_tvalid |-> (hue < HUE_LIMIT), "hue out of range")
  // zero saturation only for grey, which has zero hue
  `RHC_ASSERT(a_grey_hue, out_tvalid && (sat == '0) |-> (hue == '0), "grey word with hue")
  `RHC_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind rgb_to_hsv_converter_top rhc_checker u_rhc_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsv_converter_top: random and directed pixels in,
// HSV words checked in order against a local predictor. Depends on rhc_pkg and the RTL.
module tb_top import rhc_pkg::*;;

  localparam int LATENCY    = 14;
  localparam int N_RANDOM   = 1430;
  localparam int TAIL_WORDS = 200;  // no idling once this few pixels are left
  localparam int LONG_HOLD  = 80;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [COMP_W-1:0] sat;
    logic [COMP_W-1:0] value;
  } hsv_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;

  pixel_t pixel_queue[$];
  hsv_t   hsv_due[$];
  pixel_t next_pix;
  pixel_t taken_pix;
  hsv_t   want;
  hsv_t   got;
  bit     in_took;
  int     in_gap;
  int     out_hold;
  int     in_idle_pct = 20;
  int     out_idle_pct = 20;
  int     words_in;
  int     words_out;
  int     failures;
  bit     long_hold_done;

  rgb_to_hsv_converter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hsv_t predict_hsv(pixel_t p);
    int   r, g, b, mx, mn, delta, base, a, c, q, h;
    hsv_t o;
    r  = p.red;
    g  = p.green;
    b  = p.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    if (delta == 0) begin
      h = 0;
      o.sat = '0;
    end else begin
      o.sat = COMP_W'((delta * CMAX) / mx);
      // first component equal to the maximum picks the sector
      if (r == mx) begin
        base = 0;
        a = g;
        c = b;
      end else if (g == mx) begin
        base = 2 * DEG60;
        a = b;
        c = r;
      end else begin
        base = 4 * DEG60;
        a = r;
        c = g;
      end
      if (a >= c) begin
        q = (DEG60 * (a - c)) / delta;
        h = base + q;
      end else begin
        q = (DEG60 * (c - a)) / delta;
        h = base - q;
        if (h < 0) h = h + DEG360;
      end
    end
    o.hue   = HUE_W'(h);
    o.value = COMP_W'(mx);
    return o;
  endfunction

  function automatic pixel_t make_pixel(int r, int g, int b);
    pixel_t p;
    p.red   = COMP_W'(r);
    p.green = COMP_W'(g);
    p.blue  = COMP_W'(b);
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     mode, lvl, lo;
    mode = $urandom_range(0, 9);
    p = make_pixel($urandom_range(0, CMAX), $urandom_range(0, CMAX), $urandom_range(0, CMAX));
    case (mode)
      6: begin  // grey
        lvl = $urandom_range(0, CMAX);
        p = make_pixel(lvl, lvl, lvl);
      end
      7: begin  // two components tie for the maximum
        lvl = $urandom_range(1, CMAX);
        lo  = $urandom_range(0, lvl - 1);
        case ($urandom_range(0, 2))
          0: p = make_pixel(lvl, lvl, lo);
          1: p = make_pixel(lo, lvl, lvl);
          default: p = make_pixel(lvl, lo, lvl);
        endcase
      end
      8: begin  // near-grey, small delta
        lvl = $urandom_range(0, CMAX - 3);
        p = make_pixel(lvl + $urandom_range(0, 3), lvl + $urandom_range(0, 3),
                       lvl + $urandom_range(0, 3));
      end
      9: begin  // components at the rails
        p.red   = $urandom_range(0, 1) ? COMP_W'(CMAX) : p.red;
        p.green = $urandom_range(0, 1) ? '0 : p.green;
        p.blue  = $urandom_range(0, 1) ? COMP_W'(CMAX) : '0;
      end
      default: ;
    endcase
    return p;
  endfunction

  // sampling side: take input words into the prediction queue, check result words
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        taken_pix.red   = in_tdata[0 +: COMP_W];
        taken_pix.green = in_tdata[COMP_W +: COMP_W];
        taken_pix.blue  = in_tdata[2*COMP_W +: COMP_W];
        hsv_due.push_back(predict_hsv(taken_pix));
        in_took = 1'b1;
        words_in++;
        if (words_in % 128 == 0) in_idle_pct = $urandom_range(0, 3) * 10;
      end
      if (out_tvalid && out_tready) begin
        got.hue   = out_tdata[HUE_LSB +: HUE_W];
        got.sat   = out_tdata[SAT_LSB +: COMP_W];
        got.value = out_tdata[VAL_LSB +: COMP_W];
        if (hsv_due.size() == 0) begin
          $error("result word with nothing pending: %h", out_tdata);
          failures++;
        end else begin
          want = hsv_due.pop_front();
          if (got.hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, got.hue);
            failures++;
          end
          if (got.sat !== want.sat) begin
            $error("saturation: expected %0d, got %0d", want.sat, got.sat);
            failures++;
          end
          if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got.value);
            failures++;
          end
        end
        words_out++;
        if (words_out % 128 == 0) out_idle_pct = $urandom_range(0, 3) * 10;
      end
    end
  end

  // sender: holds a word until taken, idles in short bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (pixel_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pixel_queue.size() > TAIL_WORDS &&
                   $urandom_range(0, 99) < in_idle_pct) begin
        in_gap = $urandom_range(0, 5);
        in_tvalid <= 1'b0;
      end else begin
        next_pix = pixel_queue.pop_front();
        in_tdata  <= IN_TW'({next_pix.blue, next_pix.green, next_pix.red});
        in_tvalid <= 1'b1;
      end
    end
    in_took = 1'b0;
  end

  // receiver: short random stalls plus one long hold-off to back the pipe up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else if (!long_hold_done && words_out >= 300) begin
      long_hold_done = 1'b1;
      out_hold = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (pixel_queue.size() > TAIL_WORDS &&
                 $urandom_range(0, 99) < out_idle_pct) begin
      out_hold = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    // directed corners: grey and black, primaries, ties, wrap of a negative red hue
    pixel_queue.push_back(make_pixel(0, 0, 0));
    pixel_queue.push_back(make_pixel(255, 255, 255));
    pixel_queue.push_back(make_pixel(128, 128, 128));
    pixel_queue.push_back(make_pixel(255, 0, 0));
    pixel_queue.push_back(make_pixel(0, 255, 0));
    pixel_queue.push_back(make_pixel(0, 0, 255));
    pixel_queue.push_back(make_pixel(255, 255, 0));
    pixel_queue.push_back(make_pixel(0, 255, 255));
    pixel_queue.push_back(make_pixel(255, 0, 255));
    pixel_queue.push_back(make_pixel(255, 0, 1));
    pixel_queue.push_back(make_pixel(255, 1, 0));
    pixel_queue.push_back(make_pixel(255, 0, 128));
    pixel_queue.push_back(make_pixel(1, 0, 0));
    pixel_queue.push_back(make_pixel(0, 1, 0));
    pixel_queue.push_back(make_pixel(0, 0, 1));
    pixel_queue.push_back(make_pixel(1, 1, 0));
    pixel_queue.push_back(make_pixel(255, 254, 254));
    pixel_queue.push_back(make_pixel(254, 255, 255));
    pixel_queue.push_back(make_pixel(1, 255, 0));
    pixel_queue.push_back(make_pixel(200, 50, 100));
    pixel_queue.push_back(make_pixel(100, 200, 50));
    pixel_queue.push_back(make_pixel(50, 100, 200));
    pixel_queue.push_back(make_pixel(170, 85, 51));
    repeat (N_RANDOM) pixel_queue.push_back(random_pixel());

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pixel_queue.size() != 0 || in_tvalid || hsv_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
    if (failures == 0) begin
      $display("rgb_to_hsv_converter_top verification clean");
    end else begin
      $display("rgb_to_hsv_converter_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rgb_to_hsv_converter_top verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rhc_pkg.sv
sv/rhc_front.sv
sv/rhc_cell.sv
sv/rhc_back.sv
sv/rgb_to_hsv_converter_top.sv
sv/rhc_checker.sv
tb/tb_top.sv
